### rtl/keypad_digit_substring_match_assert.svh
// Assertion macros for the keypad digit matcher.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef KEYPAD_DIGIT_SUBSTRING_MATCH_ASSERT_SVH
`define KEYPAD_DIGIT_SUBSTRING_MATCH_ASSERT_SVH

// Generic clocked check with an active-low reset that disables it.
`define KDSM_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check on the block clock and reset.
`define KDSM_ASSERT(lbl, prop, msg) \
  `KDSM_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/kdsm_pkg.sv
// Shared types, constants and character mapping for the keypad digit matcher.
// No dependencies; imported by the match core and the top level.
`timescale 1ns / 1ps

package kdsm_pkg;

  // Default window depth, which is also the longest usable pattern
  localparam int unsigned MaxPatternDef = 16;

  // Configuration register indexes (byte address is 8 * index)
  localparam logic [1:0] RegPatternDigits = 2'd0;
  localparam logic [1:0] RegPatternLength = 2'd1;
  localparam logic [1:0] RegMatchMode     = 2'd2;

  // Match modes
  localparam logic ModeSubstring   = 1'b0;
  localparam logic ModeSubsequence = 1'b1;

  // Keypad digit for each letter a..z
  localparam logic [3:0] LetterKey [26] = '{
    4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9
  };

  // One input request as seen by the match core
  typedef struct packed {
    logic [7:0] char_code;
    logic       char_valid;
    logic       in_number_field;
    logic       field_start;
    logic       contact_end;
  } kdsm_item_t;

  // Mapped character: hit is low when the byte carries no digit
  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } kdsm_digit_t;

  // Map a raw byte to a keypad digit; letters only count in a name
  function automatic kdsm_digit_t map_char(logic [7:0] code, logic number);
    kdsm_digit_t res;
    logic [7:0]  lower;
    logic [7:0]  offs;
    res   = '{hit: 1'b0, value: 4'd0};
    lower = code | 8'h20;
    offs  = lower - 8'h61;
    if (code inside {[8'h30 : 8'h39]}) begin
      res.hit   = 1'b1;
      res.value = code[3:0];
    end else if (code == 8'h2B) begin
      res.hit   = 1'b1;
      res.value = 4'd0;
    end else if (!number && (code inside {[8'h41 : 8'h5A], [8'h61 : 8'h7A]})) begin
      res.hit   = 1'b1;
      res.value = LetterKey[offs[4:0]];
    end
    return res;
  endfunction

  // Pattern nibble at a digit position, first digit lowest
  function automatic logic [3:0] pat_nib(logic [63:0] pat, logic [3:0] idx);
    return pat[{idx, 2'b00} +: 4];
  endfunction

endpackage

### rtl/kdsm_match_core.sv
// Digit window, subsequence tracker and per-contact match flag.
// Depends on kdsm_pkg for the item struct and the character mapping.
`timescale 1ns / 1ps

module kdsm_match_core import kdsm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  kdsm_item_t  item_i,
  input  logic [63:0] pattern_digits_i,
  input  logic [4:0]  pattern_length_i,
  input  logic        match_mode_i,
  output logic        matched_o
);

  localparam int unsigned CntW = $clog2(MAX_PATTERN + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PATTERN);

  logic [3:0]      win_q [MAX_PATTERN];
  logic [3:0]      win_d [MAX_PATTERN];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic            seen_q, seen_d;

  logic [CntW-1:0] len;
  logic [CntW-1:0] cnt_s, pos_s, cnt_n, pos_n;
  logic            seen_n;
  logic            take, brk, run;
  logic [MAX_PATTERN:0] run_by_len;
  kdsm_digit_t     dig;

  // Saturate the pattern length to the window depth
  assign len = (pattern_length_i > 5'(MAX_PATTERN)) ? CntMax : CntW'(pattern_length_i);

  assign dig  = map_char(item_i.char_code, item_i.in_number_field);
  assign take = item_i.char_valid && dig.hit;
  assign brk  = item_i.char_valid && !dig.hit && item_i.in_number_field;

  // Field start clears the trackers before the character is taken
  assign cnt_s = item_i.field_start ? '0 : cnt_q;
  assign pos_s = item_i.field_start ? '0 : pos_q;

  // Shift the new digit into the window
  always_comb begin
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      win_d[i] = take ? win_q[i + 1] : win_q[i];
    end
    win_d[MAX_PATTERN - 1] = take ? dig.value : win_q[MAX_PATTERN - 1];
  end

  // Compare the newest digits against every candidate pattern length
  always_comb begin
    run_by_len[0] = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      run_by_len[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win_d[MAX_PATTERN - l + i] != pattern_digits_i[4*i +: 4]) begin
          run_by_len[l] = 1'b0;
        end
      end
    end
  end

  // Advance counters and the match flag
  always_comb begin
    cnt_n  = cnt_s;
    pos_n  = pos_s;
    seen_n = seen_q;
    run    = 1'b0;
    if (take) begin
      cnt_n = (cnt_s == CntMax) ? cnt_s : cnt_s + 1'b1;
      run   = (len != '0) && (cnt_n >= len) && run_by_len[len];
      if ((pos_s < len) && (dig.value == pat_nib(pattern_digits_i, 4'(pos_s)))) begin
        pos_n = pos_s + 1'b1;
      end
      if (match_mode_i == ModeSubsequence) begin
        if ((len != '0) && (pos_n == len)) seen_n = 1'b1;
      end else if (run) begin
        seen_n = 1'b1;
      end
    end else if (brk) begin
      cnt_n = '0;
    end
  end

  assign matched_o = seen_n || (len == '0);

  // Contact end returns all trackers to their reset value
  always_comb begin
    cnt_d  = cnt_n;
    pos_d  = pos_n;
    seen_d = seen_n;
    if (item_i.contact_end) begin
      cnt_d  = '0;
      pos_d  = '0;
      seen_d = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pos_q  <= '0;
      seen_q <= 1'b0;
    end else if (accept_i) begin
      cnt_q  <= cnt_d;
      pos_q  <= pos_d;
      seen_q <= seen_d;
    end
  end

  // Window contents are only read below the digit count, so no reset
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

endmodule

### rtl/keypad_digit_substring_match.sv
// Keypad digit matcher: one character per request in, one match flag per contact out.
// The result is loaded into the output register when the contact-end request is accepted.
// Throughput: one request per cycle unless stalled; the window compare in the match core is combinational.
// Requests stall only while a result waits in the output register and is not taken.
// Reset (rst_ni, asynchronous, active low) clears configuration registers, trackers and the output valid.
// Depends on kdsm_pkg, kdsm_match_core and the assertion macro header.
`timescale 1ns / 1ps
`include "keypad_digit_substring_match_assert.svh"

module keypad_digit_substring_match import kdsm_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MaxPatternDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input character stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [2:0]  s_axis_tuser,   // [0] char_valid, [1] in_number_field, [2] field_start
  input  logic        s_axis_tlast,   // contact_end
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] contact_matched, [7:1] zero
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0] pattern_digits_q;
  logic [4:0]  pattern_length_q;
  logic        match_mode_q;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  logic        in_acc;
  logic        matched;
  kdsm_item_t  item;
  logic        out_valid_q, out_valid_d;
  logic        out_match_q;

  // Configuration writes and reads
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_digits_q <= '0;
      pattern_length_q <= '0;
      match_mode_q     <= ModeSubstring;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegPatternDigits: pattern_digits_q <= pwdata;
        RegPatternLength: pattern_length_q <= pwdata[4:0];
        RegMatchMode:     match_mode_q     <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPatternDigits: prdata = pattern_digits_q;
      RegPatternLength: prdata = {59'd0, pattern_length_q};
      RegMatchMode:     prdata = {63'd0, match_mode_q};
      default:          prdata = '0;
    endcase
  end

  // Take a request whenever the output register is free or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign item = '{
    char_code:       s_axis_tdata,
    char_valid:      s_axis_tuser[0],
    in_number_field: s_axis_tuser[1],
    field_start:     s_axis_tuser[2],
    contact_end:     s_axis_tlast
  };

  kdsm_match_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_acc),
    .item_i           (item),
    .pattern_digits_i (pattern_digits_q),
    .pattern_length_i (pattern_length_q),
    .match_mode_i     (match_mode_q),
    .matched_o        (matched)
  );

  // Output register: load on contact end, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    if (in_acc && s_axis_tlast) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      out_match_q <= matched;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_match_q};

  // Checks
  `KDSM_ASSERT(a_end_gives_result, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid, "contact end did not load a result")
  `KDSM_ASSERT(a_no_spurious_result, (s_axis_tvalid && s_axis_tready && !s_axis_tlast && (!m_axis_tvalid || m_axis_tready)) |=> !m_axis_tvalid, "result without contact end")
  `KDSM_ASSERT(a_empty_pattern_matches, (s_axis_tvalid && s_axis_tready && s_axis_tlast && (pattern_length_q == 5'd0)) |=> m_axis_tdata[0], "empty pattern must match")
  `KDSM_ASSERT(a_stall_only_on_full, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled with free output")

endmodule

### test/tb.sv
// Self-checking bench for keypad_digit_substring_match: streams contacts, predicts match flags.
// Depends on kdsm_pkg and the keypad_digit_substring_match top level.
`timescale 1ns / 1ps

module tb;
  import kdsm_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseItems  = 150;
  localparam int unsigned NumPhases   = 12;
  localparam logic [4:0]  NoKey       = 5'd16;

  // One character request as it travels on the input stream
  typedef struct packed {
    logic [7:0] code;
    logic [2:0] user;   // [0] char_valid, [1] in_number_field, [2] field_start
    logic       last;   // contact_end
  } char_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [63:0] pwdata        = '0;
  logic [63:0] prdata;
  logic        pready;

  // Pending character requests and predicted match flags
  char_req_t   char_requests_q [$];
  logic        match_flags_q [$];

  // Predictor copy of configuration and tracker state
  logic [63:0] cfg_pat  = '0;
  logic [4:0]  cfg_len  = '0;
  logic        cfg_mode = ModeSubstring;
  logic [3:0]  key_window [16];
  logic [4:0]  window_fill = '0;
  logic [4:0]  seq_pos     = '0;
  logic        contact_hit = 1'b0;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned phase_pushed   = 0;
  logic        req_taken      = 1'b0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          rx_left        = 0;
  int          rx_mode        = 0;

  keypad_digit_substring_match DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [4:0] active_len();
    return (cfg_len > 5'd16) ? 5'd16 : cfg_len;
  endfunction

  function automatic logic [3:0] pattern_digit(input int idx);
    return cfg_pat[idx*4 +: 4];
  endfunction

  // Keypad digit of a byte, NoKey when it carries none
  function automatic logic [4:0] key_digit(input logic [7:0] c, input logic num);
    logic [7:0] lc;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c == 8'h2B) return 5'd0;
    if (num) return NoKey;
    lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    if (lc >= 8'h61 && lc <= 8'h63) return 5'd2;
    if (lc >= 8'h64 && lc <= 8'h66) return 5'd3;
    if (lc >= 8'h67 && lc <= 8'h69) return 5'd4;
    if (lc >= 8'h6A && lc <= 8'h6C) return 5'd5;
    if (lc >= 8'h6D && lc <= 8'h6F) return 5'd6;
    if (lc >= 8'h70 && lc <= 8'h73) return 5'd7;
    if (lc >= 8'h74 && lc <= 8'h76) return 5'd8;
    if (lc >= 8'h77 && lc <= 8'h7A) return 5'd9;
    return NoKey;
  endfunction

  task automatic clear_window();
    for (int i = 0; i < 16; i++) key_window[i] = 4'hF;
    window_fill = '0;
  endtask

  // Advance the trackers by one accepted request; queue a flag on contact end
  task automatic track_char(input logic [7:0] code, input logic [2:0] user, input logic last);
    logic [4:0] d;
    logic [4:0] plen;
    logic       run;
    plen = active_len();
    if (user[2]) begin
      clear_window();
      seq_pos = '0;
    end
    if (user[0]) begin
      d = key_digit(code, user[1]);
      if (d != NoKey) begin
        for (int i = 0; i < 15; i++) key_window[i] = key_window[i+1];
        key_window[15] = d[3:0];
        if (window_fill < 5'd16) window_fill++;
        run = (plen != 0) && (window_fill >= plen);
        for (int i = 0; i < plen; i++)
          if (key_window[16 - plen + i] != pattern_digit(i)) run = 1'b0;
        if (seq_pos < plen && d[3:0] == pattern_digit(seq_pos)) seq_pos++;
        if (cfg_mode == ModeSubsequence) begin
          if (plen != 0 && seq_pos == plen) contact_hit = 1'b1;
        end else if (run) begin
          contact_hit = 1'b1;
        end
      end else if (user[1]) begin
        clear_window();
      end
    end
    if (last) begin
      match_flags_q.push_back(contact_hit || plen == 0);
      clear_window();
      seq_pos     = '0;
      contact_hit = 1'b0;
    end
  endtask

  initial clear_window();

  // ---------------------------------------------------------------------------
  // Monitor: check results first, then predict from the accepted request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    logic exp_flag;
    req_taken <= s_axis_tvalid && s_axis_tready;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (match_flags_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %02h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          exp_flag = match_flags_q.pop_front();
          if (m_axis_tdata !== {7'b0, exp_flag}) begin
            $display("%0t: contact_matched expected %02h, actual %02h",
                     $time, {7'b0, exp_flag}, m_axis_tdata);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) track_char(s_axis_tdata, s_axis_tuser, s_axis_tlast);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: send queued requests in bursts with random gaps
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    char_req_t req;
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (gap_left > 0 || char_requests_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        req = char_requests_q.pop_front();
        s_axis_tdata  <= req.code;
        s_axis_tuser  <= req.user;
        s_axis_tlast  <= req.last;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(60, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 25);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Receiver stall pattern: free run, coin flips, periodic and long stalls
  always @(negedge clk_i) begin : receiver
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ((rx_left % 5) < 2);
      default: m_axis_tready <= (rx_left < 3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegPatternDigits) cfg_pat = val;
    else if (idx == RegPatternLength) cfg_len = val[4:0];
    else if (idx == RegMatchMode) cfg_mode = val[0];
  endtask

  task automatic configure(input logic [63:0] pat, input logic [4:0] len, input logic mode);
    write_reg(RegPatternDigits, pat);
    write_reg(RegPatternLength, {59'b0, len});
    write_reg(RegMatchMode, {63'b0, mode});
    @(posedge clk_i);
  endtask

  // Hold until every request is sent and every flag has come, then let the pipe settle
  task automatic drain_requests();
    while (char_requests_q.size() != 0 || s_axis_tvalid || match_flags_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_req(input logic [7:0] code, input logic valid, input logic num,
                          input logic start, input logic last);
    char_requests_q.push_back('{code: code, user: {start, num, valid}, last: last});
    phase_pushed++;
  endtask

  // A name byte that maps to digit d
  function automatic logic [7:0] name_char_of(input logic [3:0] d);
    logic [7:0] base;
    int         span;
    logic [7:0] c;
    span = 3;
    case (d)
      4'd0: return ($urandom_range(0, 1) != 0) ? 8'h2B : 8'h30;
      4'd1: return 8'h31;
      4'd2: base = 8'h61;
      4'd3: base = 8'h64;
      4'd4: base = 8'h67;
      4'd5: base = 8'h6A;
      4'd6: base = 8'h6D;
      4'd7: begin
        base = 8'h70;
        span = 4;
      end
      4'd8: base = 8'h74;
      4'd9: begin
        base = 8'h77;
        span = 4;
      end
      default: return 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 2) == 0) return 8'h30 + {4'b0, d};
    c = base + 8'($urandom_range(0, span - 1));
    if ($urandom_range(0, 1) != 0) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] number_char_of(input logic [3:0] d);
    if (d == 4'd0) return ($urandom_range(0, 1) != 0) ? 8'h2B : 8'h30;
    if (d > 4'd9) return 8'($urandom_range(0, 255));
    return 8'h30 + {4'b0, d};
  endfunction

  function automatic logic [7:0] random_char(input logic num);
    int k;
    logic [7:0] c;
    k = $urandom_range(0, 9);
    if (num) begin
      if (k <= 6) return 8'h30 + 8'($urandom_range(0, 9));
      if (k == 7) return 8'h2B;
      if (k == 8) return 8'($urandom_range(8'h20, 8'h2F));
      return 8'($urandom_range(0, 255));
    end
    if (k <= 4) begin
      c = 8'h61 + 8'($urandom_range(0, 25));
      return ($urandom_range(0, 1) != 0) ? c - 8'h20 : c;
    end
    if (k <= 6) return 8'h30 + 8'($urandom_range(0, 9));
    if (k == 7) return 8'h2B;
    if (k == 8) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h2F));
  endfunction

  // One field: random prefix and suffix, optionally the pattern between (with fillers in subsequence mode)
  task automatic gen_field(input logic num, input bit embed);
    logic [7:0] chars [$];
    logic [4:0] plen;
    logic [3:0] d;
    int         n;
    bit         lead_marker;
    plen = active_len();
    n = $urandom_range(0, 6);
    repeat (n) chars.push_back(random_char(num));
    if (embed) begin
      for (int i = 0; i < plen; i++) begin
        d = pattern_digit(i);
        if (cfg_mode == ModeSubsequence && $urandom_range(0, 2) == 0)
          chars.push_back(random_char(num));
        if ($urandom_range(0, 15) == 0) d = d + 4'd1;
        chars.push_back(num ? number_char_of(d) : name_char_of(d));
      end
    end
    n = $urandom_range(0, 6);
    repeat (n) chars.push_back(random_char(num));
    lead_marker = (chars.size() == 0) || ($urandom_range(0, 2) == 0);
    if (lead_marker) push_req(8'($urandom_range(0, 255)), 1'b0, num, 1'b1, 1'b0);
    foreach (chars[i]) push_req(chars[i], 1'b1, num, (i == 0) && !lead_marker, 1'b0);
  endtask

  // Mostly well-formed contacts, with some noise requests mixed in
  task automatic gen_contact();
    int where;
    int order;
    if ($urandom_range(0, 9) == 0) begin
      push_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
      return;
    end
    where = $urandom_range(0, 3);
    order = $urandom_range(0, 5);
    case (order)
      0: gen_field(1'b0, where[0]);
      1: gen_field(1'b1, where[1]);
      2: begin
        gen_field(1'b1, where[1]);
        gen_field(1'b0, where[0]);
      end
      default: begin
        gen_field(1'b0, where[0]);
        gen_field(1'b1, where[1]);
      end
    endcase
    if ($urandom_range(0, 2) == 0)
      push_req(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'b1);
    else
      char_requests_q[$].last = 1'b1;
  endtask

  function automatic logic [63:0] random_pattern();
    logic [63:0] p;
    for (int i = 0; i < 16; i++) p[i*4 +: 4] = 4'($urandom_range(0, 9));
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [7:0] name_chars [11];
    logic [7:0] num_chars [8];
    logic [63:0] pat;
    logic [4:0]  len;
    logic        mode;
    name_chars = '{8'h00, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80, 8'hFF, 8'h5A, 8'h7A, 8'h50, 8'h61};
    num_chars  = '{8'h2B, 8'h39, 8'h30, 8'h2F, 8'h3A, 8'h37, 8'h41, 8'h32};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty pattern after reset: a bare marker contact matches
    push_req(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    drain_requests();

    // Pattern 7,2 with junk in the upper nibbles; byte extremes in a name and a number
    configure(64'hFFFF_FFFF_FFFF_FF27, 5'd2, ModeSubstring);
    foreach (name_chars[i]) push_req(name_chars[i], 1'b1, 1'b0, i == 0, i == 10);
    foreach (num_chars[i]) push_req(num_chars[i], 1'b1, 1'b1, i == 0, 1'b0);
    push_req(8'hFF, 1'b0, 1'b1, 1'b0, 1'b1);
    drain_requests();

    // Random phases over a spread of settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      pat  = random_pattern();
      len  = 5'($urandom_range(1, 6));
      mode = 1'($urandom_range(0, 1));
      case (ph)
        0: begin
          len  = 5'd16;
          mode = ModeSubstring;
        end
        1: begin
          len  = 5'd16;
          mode = ModeSubsequence;
        end
        2: begin
          pat = '1;
          len = 5'd0;
        end
        3: begin
          len  = 5'd31;
          mode = ModeSubstring;
        end
        4: begin
          len  = 5'd17;
          mode = ModeSubsequence;
        end
        5: begin
          pat[7:4] = 4'hC;
          len      = 5'd3;
        end
        6: begin
          pat  = '0;
          len  = 5'd1;
          mode = ModeSubstring;
        end
        default: ;
      endcase
      configure(pat, len, mode);
      phase_pushed = 0;
      while (phase_pushed < PhaseItems) gen_contact();
      // Leave a contact open so the next setting lands mid-contact
      if (ph[0]) gen_field(1'b1, 1'b1);
      drain_requests();
    end

    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0 && match_flags_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
